// ===== rtl/core/cswm_pkg.sv =====
package cswm_pkg;

    // Default sizing
    localparam int MAX_FRAME_DEF       = 4096;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int COS_TABLE_DEPTH_DEF = 1024;

    // Register field widths and reset values
    localparam int KIND_W  = 2;
    localparam int FLEN_W  = 13;
    localparam int PHASE_W = 32;

    localparam logic [FLEN_W-1:0]  FRAME_LENGTH_RST = 13'd1024;
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 32'd4198404;

    // Cosine table: Q16 entries, 1.0 needs 17 bits
    localparam int          COS_W       = 17;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Coefficients are Q1.16, all below 2.0 and non-negative
    localparam int COEF_W = 17;

    // Harmonic counter
    localparam int TERM_W = 3;

    typedef enum logic [1:0] {
        REG_WINDOW_KIND  = 2'd0,
        REG_FRAME_LENGTH = 2'd1,
        REG_PHASE_STEP   = 2'd2
    } reg_index_t;

    typedef enum logic [KIND_W-1:0] {
        WIN_HANN     = 2'd0,
        WIN_HAMMING  = 2'd1,
        WIN_BLACKMAN = 2'd2,
        WIN_FLATTOP  = 2'd3
    } win_kind_t;

    // Magnitude of coefficient a[m]; odd harmonics are subtracted
    function automatic logic [COEF_W-1:0] win_coef(input win_kind_t kind,
                                                   input logic [TERM_W-1:0] m);
        logic [COEF_W-1:0] c;
        c = '0;
        case (kind)
            WIN_HANN:
            begin
                case (m)
                    3'd0:    c = 17'd32768;
                    3'd1:    c = 17'd32768;
                    default: c = '0;
                endcase
            end
            WIN_HAMMING:
            begin
                case (m)
                    3'd0:    c = 17'd35389;
                    3'd1:    c = 17'd30147;
                    default: c = '0;
                endcase
            end
            WIN_BLACKMAN:
            begin
                case (m)
                    3'd0:    c = 17'd27525;
                    3'd1:    c = 17'd32768;
                    3'd2:    c = 17'd5243;
                    default: c = '0;
                endcase
            end
            WIN_FLATTOP:
            begin
                case (m)
                    3'd0:    c = 17'd14128;
                    3'd1:    c = 17'd27304;
                    3'd2:    c = 17'd18171;
                    3'd3:    c = 17'd5477;
                    3'd4:    c = 17'd455;
                    default: c = '0;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    // Index of the highest non-zero harmonic
    function automatic logic [TERM_W-1:0] win_last_term(input win_kind_t kind);
        logic [TERM_W-1:0] n;
        case (kind)
            WIN_HANN:     n = 3'd1;
            WIN_HAMMING:  n = 3'd1;
            WIN_BLACKMAN: n = 3'd2;
            WIN_FLATTOP:  n = 3'd4;
            default:      n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/cosine_sum_window_multiplier_core.sv =====
// Processing: each sample steps through S_IDX, S_ROM and S_TERM once for each of T
// cosine terms (Hann 2, Hamming 2, Blackman 3, flat-top 5), then S_SUM, S_SCALE, S_OUT.
// A new sample is taken only in S_IDLE, once the last has reached the output register; the
// single shared multiplier is used twice per term plus once for the final scaling.
// Reset: asynchronous, active low; registers return to Hann, N = 1024, default step,
// with the sample counter and phase at zero. No table clearing pass is needed.
module cosine_sum_window_multiplier_core
    import cswm_pkg::*;
#(
    parameter int MAX_FRAME       = MAX_FRAME_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // [SAMPLE_BITS-1:0] sample_in
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,

    // [SAMPLE_BITS-1:0] sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [PHASE_W-1:0]                   cfg_data
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(MAX_FRAME);
    localparam int CMP_W  = (IDX_W + 1 > FLEN_W) ? IDX_W + 1 : FLEN_W;
    localparam int RA_W   = $clog2(COS_TABLE_DEPTH + 1);
    localparam int A_W    = (SAMPLE_BITS > COS_W + 1) ? SAMPLE_BITS : COS_W + 1;
    localparam int B_W    = 34;
    localparam int P_W    = A_W + B_W;

    localparam logic signed [P_W-1:0] SAT_MAX  = P_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [P_W-1:0] SAT_MIN  = -SAT_MAX - P_W'(1);
    localparam logic signed [P_W-1:0] RND_IDX  = P_W'(64'd1 << 29);
    localparam logic signed [P_W-1:0] RND_OUT  = P_W'(64'd1 << 31);

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX,
        S_ROM,
        S_TERM,
        S_SUM,
        S_SCALE,
        S_OUT
    } state_t;

    // Quarter-wave cosine entry, Q16, from an integer Taylor series to x^14
    function automatic logic [COS_W-1:0] cos_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] t;
        x  = (HALF_PI_Q30 * 64'(k) + 64'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        r  = ONE_Q30;
        t  = ((x2 * r) >> 30) / 182;
        r  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 132;
        r  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 90;
        r  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 56;
        r  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 30;
        r  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 12;
        r  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 2;
        r  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        return COS_W'((r + 64'd8192) >> 14);
    endfunction

    logic [COS_W-1:0] cos_rom [COS_TABLE_DEPTH+1];

    for (genvar k = 0; k <= COS_TABLE_DEPTH; k++)
    begin : g_rom
        assign cos_rom[k] = cos_entry(k);
    end

    state_t                   state_reg;
    logic [KIND_W-1:0]        window_kind_reg;
    logic [FLEN_W-1:0]        frame_length_reg;
    logic [PHASE_W-1:0]       phase_step_reg;
    logic [IDX_W-1:0]         sample_index_reg;
    logic [PHASE_W-1:0]       phase_acc_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [TERM_W-1:0]        term_reg;
    logic [PHASE_W-1:0]       hphase_reg;
    logic [COS_W-1:0]         rom_q_reg;
    logic                     cos_neg_reg;
    logic signed [P_W-1:0]    prod_reg;
    logic signed [B_W-1:0]    sum_reg;

    logic [SAMPLE_BITS-1:0]   out_sample_reg;
    logic                     out_last_reg;
    logic                     out_valid_reg;

    // Shared multiplier
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [P_W-1:0]    mul_p;

    logic [RA_W-1:0]          rom_idx;
    logic [RA_W-1:0]          rom_addr;
    logic signed [P_W-1:0]    idx_round;
    logic signed [COS_W:0]    cos_term;
    logic signed [P_W-1:0]    out_round;
    logic [SAMPLE_BITS-1:0]   out_sat;
    logic [CMP_W-1:0]         len_eff;
    logic [CMP_W-1:0]         index_plus;
    logic                     frame_end;
    logic                     out_free;
    win_kind_t                kind;

    assign kind = win_kind_t'(window_kind_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_IDX:
            begin
                mul_a = A_W'(COS_TABLE_DEPTH);
                mul_b = B_W'(hphase_reg[29:0]);
            end
            S_TERM:
            begin
                mul_a = A_W'(cos_term);
                mul_b = B_W'(win_coef(kind, term_reg));
            end
            S_SCALE:
            begin
                mul_a = A_W'(sample_reg);
                mul_b = sum_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Table index from the scaled quadrant fraction; mirror in odd quadrants
    assign idx_round = prod_reg + RND_IDX;
    assign rom_idx   = idx_round[30 +: RA_W];
    assign rom_addr  = hphase_reg[30] ? RA_W'(COS_TABLE_DEPTH) - rom_idx : rom_idx;

    assign cos_term = cos_neg_reg ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});

    // Floor of (product + half) / 2^32, then clamp
    assign out_round = (prod_reg + RND_OUT) >>> 32;
    assign out_sat   = (out_round > SAT_MAX) ? SAT_MAX[SAMPLE_BITS-1:0] :
                       (out_round < SAT_MIN) ? SAT_MIN[SAMPLE_BITS-1:0] :
                       out_round[SAMPLE_BITS-1:0];

    assign len_eff    = (CMP_W'(frame_length_reg) > CMP_W'(MAX_FRAME)) ?
                        CMP_W'(MAX_FRAME) : CMP_W'(frame_length_reg);
    assign index_plus = CMP_W'(sample_index_reg) + CMP_W'(1);
    assign frame_end  = (index_plus >= len_eff);

    assign out_free = !out_valid_reg || m_axis_tready;

    // Take register writes only between samples; a pending write goes first
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tdata  = DATA_W'(out_sample_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_kind_reg  <= WIN_HANN;
            frame_length_reg <= FRAME_LENGTH_RST;
            phase_step_reg   <= PHASE_STEP_RST;
            sample_index_reg <= '0;
            phase_acc_reg    <= '0;
            sample_reg       <= '0;
            term_reg         <= '0;
            hphase_reg       <= '0;
            rom_q_reg        <= '0;
            cos_neg_reg      <= 1'b0;
            prod_reg         <= '0;
            sum_reg          <= '0;
            out_sample_reg   <= '0;
            out_last_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WINDOW_KIND:  window_kind_reg  <= cfg_data[KIND_W-1:0];
                    REG_FRAME_LENGTH: frame_length_reg <= cfg_data[FLEN_W-1:0];
                    REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                    default:          ;
                endcase
            end

            if (out_valid_reg && m_axis_tready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
                        term_reg   <= '0;
                        hphase_reg <= '0;
                        state_reg  <= S_IDX;
                    end
                end
                S_IDX:
                begin
                    // fold in the previous term while the index product forms
                    prod_reg <= mul_p;
                    if (term_reg == '0)
                    begin
                        sum_reg <= '0;
                    end
                    else
                    begin
                        sum_reg <= sum_reg + B_W'(prod_reg);
                    end
                    state_reg <= S_ROM;
                end
                S_ROM:
                begin
                    rom_q_reg   <= cos_rom[rom_addr];
                    cos_neg_reg <= hphase_reg[31] ^ hphase_reg[30] ^ term_reg[0];
                    state_reg   <= S_TERM;
                end
                S_TERM:
                begin
                    prod_reg   <= mul_p;
                    hphase_reg <= hphase_reg + phase_acc_reg;
                    term_reg   <= term_reg + TERM_W'(1);
                    if (term_reg == win_last_term(kind))
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        state_reg <= S_IDX;
                    end
                end
                S_SUM:
                begin
                    sum_reg   <= sum_reg + B_W'(prod_reg);
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_sample_reg <= out_sat;
                        out_last_reg   <= frame_end;
                        out_valid_reg  <= 1'b1;
                        if (frame_end)
                        begin
                            sample_index_reg <= '0;
                            phase_acc_reg    <= '0;
                        end
                        else
                        begin
                            sample_index_reg <= sample_index_reg + IDX_W'(1);
                            phase_acc_reg    <= phase_acc_reg + phase_step_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TERM) |-> (term_reg <= win_last_term(kind)))
        else $error("harmonic counter ran past the last term");

    a_rom_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROM) |-> (rom_addr <= RA_W'(COS_TABLE_DEPTH)))
        else $error("cosine table address out of range");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free && frame_end) |=>
        (sample_index_reg == '0 && phase_acc_reg == '0 && m_axis_tlast))
        else $error("frame end did not clear counter and phase");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CMP_W'(sample_index_reg) < CMP_W'(MAX_FRAME)))
        else $error("sample counter beyond the largest frame");

    a_result_after_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCALE) |=> (state_reg == S_OUT && !s_axis_tready))
        else $error("scaling step not followed by result stage");

endmodule
